@@ rtl/aat_pkg.sv @@
// Package for the aging asset table: operation codes, command/status types.
// No dependencies.
package aat_pkg;
  localparam int unsigned ID_W = 24;
  localparam int unsigned AGE_W = 8;
  localparam int unsigned THR_W = 16;
  localparam logic [AGE_W-1:0] AGE_MAX = 8'hFF;
  localparam logic [THR_W-1:0] THR_MAX = 16'hFFFF;
  localparam logic [7:0] TIMEOUT_RST = 8'd20;

  typedef enum logic [2:0] {
    OP_SEEN = 3'd0, OP_RX_TICK = 3'd1, OP_THR_TICK = 3'd2,
    OP_BUMP = 3'd3, OP_CLEAR = 3'd4
  } op_t;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture input item
    logic scan;     // visit entry at scan index
    logic commit;   // apply chosen slot for seen/bump
    logic finish;   // load output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_last;
  } sts_t;
endpackage

@@ rtl/aat_ctrl.sv @@
// Controller for the aging asset table: sequences load, per-entry scan,
// commit and result. Depends on aat_pkg.
module aat_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          out_valid,
  input  logic          out_ready,
  input  aat_pkg::sts_t sts,
  output aat_pkg::cmd_t cmd
);
  import aat_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001, S_SCAN = 3'b010, S_COMMIT = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // a new item may scan while the previous result waits; commit loads the
  // output register, so it holds until that register is free.
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (!out_valid || out_ready) begin
          cmd.commit = 1'b1;
          cmd.finish = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state not one-hot");
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == S_SCAN) else $error("load did not start scan");
  a_fin: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid || out_ready)) else $error("result overrun");
endmodule

@@ rtl/aat_dp.sv @@
// Datapath for the aging asset table: entry registers, sequential scan,
// victim search, bump tick reciprocal multiply, result register. Depends on aat_pkg.
module aat_dp #(
  parameter int unsigned ENTRIES = 16,
  parameter int unsigned TICK_PERIOD_MS = 100
) (
  input  logic          clk,
  input  logic          rst_n,
  input  aat_pkg::cmd_t cmd,
  output aat_pkg::sts_t sts,
  input  logic [7:0]    timeout_ticks,
  input  logic [2:0]    in_operation,
  input  logic [23:0]   in_asset_id,
  input  logic signed [7:0] in_rssi,
  input  logic [5:0]    in_channel,
  input  logic [3:0]    in_slot_index,
  input  logic [15:0]   in_bump_ms,
  input  logic          out_ready,
  output logic          out_valid,
  output logic [3:0]    out_slot,
  output logic          out_was_hit,
  output logic          out_was_replaced,
  output logic [15:0]   out_throttle_left,
  output logic [4:0]    out_timed_out_count
);
  import aat_pkg::*;

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);
  localparam logic [16:0] PER = 17'(TICK_PERIOD_MS);
  // ceil(2^(17+l)/P) gives an exact floor(x/P) for any 17-bit x
  localparam int unsigned DIV_SH = 17 + $clog2(TICK_PERIOD_MS);
  localparam longint unsigned RECIP_L =
    ((64'd1 << DIV_SH) + 64'(TICK_PERIOD_MS) - 64'd1) / 64'(TICK_PERIOD_MS);
  localparam logic [17:0] RECIP = 18'(RECIP_L);

  logic             valid_r [ENTRIES];
  logic [ID_W-1:0]  id_r    [ENTRIES];
  logic [AGE_W-1:0] age_r   [ENTRIES];
  logic [THR_W-1:0] thr_r   [ENTRIES];
  logic [7:0]       rssi_r  [ENTRIES];
  logic [5:0]       chan_r  [ENTRIES];

  logic [2:0]  op_r;
  logic [23:0] aid_r;
  logic [7:0]  rssi_in_r;
  logic [5:0]  chan_in_r;
  logic [3:0]  sidx_r;
  logic [IW-1:0] idx_r;
  logic        hit_r, free_r;
  logic [IW-1:0] hit_slot_r, free_slot_r, old_slot_r;
  logic [AGE_W-1:0] old_age_r;
  logic [CW-1:0] cnt_r;

  // ceil(ms/period) as floor((ms+period-1)/period)
  logic [16:0] div_r;
  logic [16:0] quo_r;
  logic [17:0] dividend;
  logic [34:0] prod;

  logic [IW-1:0] sel;
  logic [IW-1:0] sidx_i;
  logic          in_range;
  logic [16:0]   bsum;
  logic [THR_W-1:0] bnew;
  logic [AGE_W-1:0] age_inc;

  assign dividend = 18'(in_bump_ms) + 18'(PER) - 18'd1;
  assign prod = 35'(div_r) * 35'(RECIP);
  assign sts.scan_last = (idx_r == LAST);
  assign in_range = (32'(sidx_r) < ENTRIES);
  assign sidx_i = IW'(sidx_r);

  always_comb begin
    if (hit_r)       sel = hit_slot_r;
    else if (free_r) sel = free_slot_r;
    else             sel = old_slot_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_operation; aid_r <= in_asset_id; rssi_in_r <= in_rssi;
      chan_in_r <= in_channel; sidx_r <= in_slot_index;
      idx_r <= '0; hit_r <= 1'b0; free_r <= 1'b0; old_slot_r <= '0;
      old_age_r <= '0; cnt_r <= '0;
      div_r <= dividend[16:0];
    end else if (cmd.scan) begin
      quo_r <= 17'(prod >> DIV_SH);
      if (idx_r != LAST) idx_r <= idx_r + 1'b1;
      if (valid_r[idx_r] && id_r[idx_r] == aid_r && !hit_r) begin
        hit_r <= 1'b1; hit_slot_r <= idx_r;
      end
      if (!valid_r[idx_r] && !free_r) begin
        free_r <= 1'b1; free_slot_r <= idx_r;
      end
      if (idx_r == '0 || age_r[idx_r] > old_age_r) begin
        old_slot_r <= idx_r; old_age_r <= age_r[idx_r];
      end
      if (op_r == OP_RX_TICK && valid_r[idx_r] && age_inc >= timeout_ticks)
        cnt_r <= cnt_r + 1'b1;
    end
  end

  assign age_inc = (age_r[idx_r] != AGE_MAX) ? age_r[idx_r] + 1'b1 : AGE_MAX;
  assign bsum = 17'(thr_r[sidx_i]) + quo_r;
  assign bnew = bsum[16] ? THR_MAX : bsum[15:0];

  // entry store; clear at reset and on clear operation
  always_ff @(posedge clk) begin
    if (!rst_n || (cmd.commit && op_r == OP_CLEAR)) begin
      for (int i = 0; i < ENTRIES; i++) begin
        valid_r[i] <= 1'b0; id_r[i] <= '0; age_r[i] <= '0;
        thr_r[i] <= '0; rssi_r[i] <= '0; chan_r[i] <= '0;
      end
    end else if (cmd.scan) begin
      if (op_r == OP_RX_TICK && valid_r[idx_r]) begin
        age_r[idx_r] <= age_inc;
        if (age_inc >= timeout_ticks) valid_r[idx_r] <= 1'b0;
      end
      if (op_r == OP_THR_TICK && valid_r[idx_r] && thr_r[idx_r] != '0)
        thr_r[idx_r] <= thr_r[idx_r] - 1'b1;
    end else if (cmd.commit) begin
      if (op_r == OP_SEEN) begin
        if (!hit_r) begin
          valid_r[sel] <= 1'b1; id_r[sel] <= aid_r; thr_r[sel] <= '0;
        end
        rssi_r[sel] <= rssi_in_r; chan_r[sel] <= chan_in_r; age_r[sel] <= '0;
      end else if (op_r == OP_BUMP && in_range) begin
        thr_r[sidx_i] <= bnew;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (cmd.finish) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_slot <= '0; out_was_hit <= 1'b0; out_was_replaced <= 1'b0;
      out_throttle_left <= '0; out_timed_out_count <= '0;
      case (op_r)
        OP_SEEN: begin
          out_slot <= 4'(sel); out_was_hit <= hit_r;
          out_was_replaced <= !hit_r && !free_r;
          out_throttle_left <= hit_r ? thr_r[sel] : '0;
        end
        OP_RX_TICK: out_timed_out_count <= 5'(cnt_r);
        OP_BUMP: begin
          out_slot <= sidx_r;
          if (in_range) out_throttle_left <= bnew;
        end
        default: ;
      endcase
    end
  end

  a_hit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && op_r == OP_SEEN && hit_r |-> valid_r[hit_slot_r])
    else $error("hit slot not valid");
  a_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && free_r |-> !valid_r[free_slot_r]) else $error("free slot valid");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= ENTRIES) else $error("timeout count overflow");
endmodule

@@ rtl/aging_asset_table_top.sv @@
// Top level of the aging asset table: APB register, controller, datapath.
// Depends on aat_pkg, aat_ctrl, aat_dp.
//
// Each operation runs from acceptance through a scan that visits one table entry
// per cycle, then a commit state that also loads the result register. The next
// item can be accepted in the same cycle the result is; a stalled result holds
// the commit of the following item. One item is scanned or committed at a time,
// besides a result waiting in the output register.
module aging_asset_table_top #(
  parameter int unsigned ENTRIES = 16,
  parameter int unsigned TICK_PERIOD_MS = 100
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_operation,
  input  logic [23:0] in_asset_id,
  input  logic signed [7:0] in_rssi,
  input  logic [5:0]  in_channel,
  input  logic [3:0]  in_slot_index,
  input  logic [15:0] in_bump_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_slot,
  output logic        out_was_hit,
  output logic        out_was_replaced,
  output logic [15:0] out_throttle_left,
  output logic [4:0]  out_timed_out_count
);
  import aat_pkg::*;

  logic [7:0] timeout_r;
  cmd_t cmd;
  sts_t sts;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {24'd0, timeout_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) timeout_r <= TIMEOUT_RST;
    else if (psel && penable && pwrite && paddr == 2'd0) timeout_r <= pwdata[7:0];
  end

  aat_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .sts, .cmd
  );

  aat_dp #(.ENTRIES(ENTRIES), .TICK_PERIOD_MS(TICK_PERIOD_MS)) u_dp (
    .clk, .rst_n, .cmd, .sts, .timeout_ticks(timeout_r),
    .in_operation, .in_asset_id, .in_rssi, .in_channel, .in_slot_index,
    .in_bump_ms, .out_ready, .out_valid, .out_slot, .out_was_hit,
    .out_was_replaced, .out_throttle_left, .out_timed_out_count
  );
endmodule
